[design/face_gradient_correction_core_macros.svh]
// assertion helpers for the face gradient correction core
`ifndef FACE_GRADIENT_CORRECTION_CORE_MACROS_SVH
`define FACE_GRADIENT_CORRECTION_CORE_MACROS_SVH

// condition checked on every rising clock edge outside reset
`define FGC_ASSERT(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// consequence checked in the cycle after the trigger
`define FGC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/fgc_pkg.sv]
`timescale 1ns / 1ps

package fgc_pkg;

   localparam logic [16:0] OneQ16   = 17'd65536;
   localparam int          DivSteps = 42;
   localparam int          M2W      = 64;
   localparam int          RemW     = 65;
   localparam int          ProdW    = 99;
   localparam logic [40:0] CorrCap  = 41'd1 << 40;

   typedef struct packed {
      logic signed [31:0] left_value;
      logic signed [31:0] right_value;
      logic signed [31:0] left_grad_x;
      logic signed [31:0] left_grad_y;
      logic signed [31:0] left_grad_z;
      logic signed [31:0] right_grad_x;
      logic signed [31:0] right_grad_y;
      logic signed [31:0] right_grad_z;
      logic        [16:0] left_weight;
      logic signed [31:0] dist_x;
      logic signed [31:0] dist_y;
      logic signed [31:0] dist_z;
   } fgc_req_type;

   typedef struct packed {
      logic signed [31:0] face_grad_x;
      logic signed [31:0] face_grad_y;
      logic signed [31:0] face_grad_z;
      logic               zero_distance;
   } fgc_rsp_type;

endpackage

[design/face_gradient_correction_core.sv]
`timescale 1ns / 1ps
// channel   ports                               direction
// req       req_valid, req_ready, req_data      in: one face per transaction
// rsp       rsp_valid, rsp_ready, rsp_data      out: one corrected gradient per face
//
// one face enters per cycle unless the output stalls; the pipeline holds the 42-step
// restoring divider (one quotient bit per stage) plus the product stages.
// reset clears only the valid bits; payload registers are not reset.
// the whole pipeline advances together: when the output register holds an
// untaken transaction, every stage and req_ready hold until rsp_ready.
`include "face_gradient_correction_core_macros.svh"

module face_gradient_correction_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  fgc_pkg::fgc_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output fgc_pkg::fgc_rsp_type rsp_data
);
   import fgc_pkg::*;

   localparam int DivBase   = 11;
   localparam int RndStage  = DivBase + DivSteps + 1;
   localparam int NumStages = RndStage + 3;

   typedef struct packed {
      logic [2:0][RemW-1:0]     rem;
      logic [2:0][DivSteps-1:0] quo;
      logic [2:0][DivSteps-1:0] low;
      logic [2:0]               ovf;
      logic [2:0]               neg;
      logic [2:0][32:0]         avg;
      logic [M2W-1:0]           m2;
      logic                     zero;
   } div_type;

   logic                 adv;
   logic [NumStages-1:0] valid_ff, valid_in;

   fgc_req_type          s0_ff;
   logic signed [31:0]   gl [3];
   logic signed [31:0]   gr [3];
   logic signed [31:0]   dd [3];

   logic signed [49:0]   s1_pl_ff [3], s1_pl_in [3];
   logic signed [49:0]   s1_pr_ff [3], s1_pr_in [3];
   logic [63:0]          s1_sq_ff [3], s1_sq_in [3];
   logic signed [32:0]   s1_diff_ff, s1_diff_in;
   logic signed [31:0]   s1_d_ff [3];

   logic signed [50:0]   s2_sum_ff [3], s2_sum_in [3];
   logic [63:0]          s2_m2a_ff, s2_m2a_in, s2_sq2_ff;
   logic signed [32:0]   s2_diff_ff;
   logic signed [31:0]   s2_d_ff [3];

   logic [31:0]          s3_rmag_ff [3], s3_rmag_in [3];
   logic [2:0]           s3_neg_ff, s3_neg_in;
   logic [63:0]          s3_m2_ff, s3_m2_in;
   logic signed [32:0]   s3_diff_ff;
   logic signed [31:0]   s3_d_ff [3];

   logic signed [32:0]   s4_avg_ff [3], s4_avg_in [3];
   logic [63:0]          s4_m2_ff;
   logic                 s4_zero_ff, s4_zero_in;
   logic signed [32:0]   s4_diff_ff;
   logic signed [31:0]   s4_d_ff [3];

   logic signed [64:0]   s5_prod_ff [3], s5_prod_in [3];
   logic signed [49:0]   s5_dterm_ff, s5_dterm_in;
   logic signed [32:0]   s5_avg_ff [3];
   logic signed [31:0]   s5_d_ff [3];
   logic [63:0]          s5_m2_ff;
   logic                 s5_zero_ff;

   logic signed [65:0]   s6_s01_ff, s6_s01_in, s6_s2d_ff, s6_s2d_in;
   logic signed [32:0]   s6_avg_ff [3];
   logic signed [31:0]   s6_d_ff [3];
   logic [63:0]          s6_m2_ff;
   logic                 s6_zero_ff;

   logic signed [66:0]   s7_n_ff, s7_n_in;
   logic signed [32:0]   s7_avg_ff [3];
   logic signed [31:0]   s7_d_ff [3];
   logic [63:0]          s7_m2_ff;
   logic                 s7_zero_ff;

   logic [66:0]          s8_nm_ff, s8_nm_in;
   logic [2:0]           s8_neg_ff, s8_neg_in;
   logic [31:0]          s8_dm_ff [3], s8_dm_in [3];
   logic signed [32:0]   s8_avg_ff [3];
   logic [63:0]          s8_m2_ff;
   logic                 s8_zero_ff;

   logic [63:0]          s9_plo_ff [3], s9_plo_in [3];
   logic [63:0]          s9_pmid_ff [3], s9_pmid_in [3];
   logic [34:0]          s9_phi_ff [3], s9_phi_in [3];
   logic [2:0]           s9_neg_ff;
   logic signed [32:0]   s9_avg_ff [3];
   logic [63:0]          s9_m2_ff;
   logic                 s9_zero_ff;

   logic [ProdW-1:0]     s10_p_ff [3], s10_p_in [3];
   logic [2:0]           s10_neg_ff;
   logic signed [32:0]   s10_avg_ff [3];
   logic [63:0]          s10_m2_ff;
   logic                 s10_zero_ff;

   div_type              div_ff [DivSteps+1];
   div_type              div_in [DivSteps+1];

   logic [40:0]          rnd_mq_ff [3], rnd_mq_in [3];
   logic [2:0]           rnd_neg_ff;
   logic signed [32:0]   rnd_avg_ff [3];
   logic                 rnd_zero_ff;

   logic signed [42:0]   sub_ff [3], sub_in [3];
   logic                 sub_zero_ff;

   fgc_rsp_type          out_ff, out_in;

   // whole pipeline moves unless the output transaction is stuck
   assign adv       = !valid_ff[NumStages-1] || rsp_ready;
   assign req_ready = adv;
   assign valid_in  = {valid_ff[NumStages-2:0], req_valid};
   assign rsp_valid = valid_ff[NumStages-1];
   assign rsp_data  = out_ff;

   assign gl[0] = s0_ff.left_grad_x;
   assign gl[1] = s0_ff.left_grad_y;
   assign gl[2] = s0_ff.left_grad_z;
   assign gr[0] = s0_ff.right_grad_x;
   assign gr[1] = s0_ff.right_grad_y;
   assign gr[2] = s0_ff.right_grad_z;
   assign dd[0] = s0_ff.dist_x;
   assign dd[1] = s0_ff.dist_y;
   assign dd[2] = s0_ff.dist_z;

   // weights, weighted products, squared distance
   always_comb begin
      logic [16:0] wl;
      logic [16:0] wr;
      logic [31:0] draw;
      logic [31:0] dm;
      wl = (s0_ff.left_weight > OneQ16) ? OneQ16 : s0_ff.left_weight;
      wr = OneQ16 - wl;
      for (int c = 0; c < 3; c++) begin
         s1_pl_in[c] = $signed({1'b0, wl}) * gl[c];
         s1_pr_in[c] = $signed({1'b0, wr}) * gr[c];
         draw        = dd[c];
         dm          = draw[31] ? (~draw + 32'd1) : draw;
         s1_sq_in[c] = {32'd0, dm} * {32'd0, dm};
      end
      s1_diff_in = $signed({s0_ff.right_value[31], s0_ff.right_value})
                 - $signed({s0_ff.left_value[31], s0_ff.left_value});
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         s2_sum_in[c] = s1_pl_ff[c] + s1_pr_ff[c];
      end
      s2_m2a_in = s1_sq_ff[0] + s1_sq_ff[1];
   end

   // rounding magnitude, ties away from zero
   always_comb begin
      logic [50:0] su;
      logic [50:0] mag;
      logic [50:0] tmp;
      for (int c = 0; c < 3; c++) begin
         su            = s2_sum_ff[c];
         mag           = su[50] ? (~su + 51'd1) : su;
         tmp           = mag + 51'h8000;
         s3_rmag_in[c] = tmp[47:16];
         s3_neg_in[c]  = su[50];
      end
      s3_m2_in = s2_m2a_ff + s2_sq2_ff;
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         s4_avg_in[c] = s3_neg_ff[c] ? -$signed({1'b0, s3_rmag_ff[c]})
                                     : $signed({1'b0, s3_rmag_ff[c]});
      end
      s4_zero_in = (s3_m2_ff == '0);
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         s5_prod_in[c] = s4_avg_ff[c] * s4_d_ff[c];
      end
      s5_dterm_in = -(50'($signed({s4_diff_ff, 16'd0})));
   end

   assign s6_s01_in = s5_prod_ff[0] + s5_prod_ff[1];
   assign s6_s2d_in = s5_prod_ff[2] + s5_dterm_ff;
   assign s7_n_in   = s6_s01_ff + s6_s2d_ff;

   // magnitude of numerator, per component sign of the correction
   always_comb begin
      logic [66:0] nraw;
      logic [31:0] draw;
      nraw     = s7_n_ff;
      s8_nm_in = nraw[66] ? (~nraw + 67'd1) : nraw;
      for (int c = 0; c < 3; c++) begin
         draw         = s7_d_ff[c];
         s8_dm_in[c]  = draw[31] ? (~draw + 32'd1) : draw;
         s8_neg_in[c] = nraw[66] ^ draw[31];
      end
   end

   // numerator times distance as three partial products
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         s9_plo_in[c]  = {32'd0, s8_nm_ff[31:0]} * {32'd0, s8_dm_ff[c]};
         s9_pmid_in[c] = {32'd0, s8_nm_ff[63:32]} * {32'd0, s8_dm_ff[c]};
         s9_phi_in[c]  = {32'd0, s8_nm_ff[66:64]} * {3'd0, s8_dm_ff[c]};
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         s10_p_in[c] = {35'd0, s9_plo_ff[c]} + {3'd0, s9_pmid_ff[c], 32'd0}
                     + {s9_phi_ff[c], 64'd0};
      end
   end

   // divider setup: quotient above its top bit means the cap applies
   always_comb begin
      logic [56:0] top;
      div_in[0]      = '0;
      div_in[0].m2   = s10_m2_ff;
      div_in[0].zero = s10_zero_ff;
      div_in[0].neg  = s10_neg_ff;
      for (int c = 0; c < 3; c++) begin
         top                = s10_p_ff[c][ProdW-1:DivSteps];
         div_in[0].rem[c]   = {8'd0, top};
         div_in[0].low[c]   = s10_p_ff[c][DivSteps-1:0];
         div_in[0].ovf[c]   = ({7'd0, top} >= s10_m2_ff);
         div_in[0].avg[c]   = s10_avg_ff[c];
      end
   end

   for (genvar k = 0; k < DivSteps; k++) begin : g_div
      localparam int Bit = DivSteps - 1 - k;
      always_comb begin
         logic [RemW-1:0] trial;
         div_in[k+1] = div_ff[k];
         for (int c = 0; c < 3; c++) begin
            trial = {div_ff[k].rem[c][RemW-2:0], div_ff[k].low[c][Bit]};
            if (trial >= {1'b0, div_ff[k].m2}) begin
               div_in[k+1].rem[c]      = trial - {1'b0, div_ff[k].m2};
               div_in[k+1].quo[c][Bit] = 1'b1;
            end else begin
               div_in[k+1].rem[c] = trial;
            end
         end
      end
   end

   // round half away from zero, cap magnitude
   always_comb begin
      logic cap;
      logic up;
      for (int c = 0; c < 3; c++) begin
         cap = div_ff[DivSteps].ovf[c] || div_ff[DivSteps].quo[c][DivSteps-1]
            || div_ff[DivSteps].quo[c][DivSteps-2];
         up  = ({div_ff[DivSteps].rem[c], 1'b0} >= {2'b00, div_ff[DivSteps].m2});
         if (div_ff[DivSteps].zero) begin
            rnd_mq_in[c] = '0;
         end else if (cap) begin
            rnd_mq_in[c] = CorrCap;
         end else begin
            rnd_mq_in[c] = {1'b0, div_ff[DivSteps].quo[c][39:0]} + {40'd0, up};
         end
      end
   end

   always_comb begin
      logic signed [42:0] a43;
      logic signed [42:0] m43;
      for (int c = 0; c < 3; c++) begin
         a43       = 43'(rnd_avg_ff[c]);
         m43       = $signed({2'b00, rnd_mq_ff[c]});
         sub_in[c] = rnd_neg_ff[c] ? (a43 + m43) : (a43 - m43);
      end
   end

   // saturate to signed 32 bits
   always_comb begin
      logic signed [31:0] sat [3];
      for (int c = 0; c < 3; c++) begin
         if (sub_ff[c] > 43'sd2147483647) begin
            sat[c] = 32'sh7fffffff;
         end else if (sub_ff[c] < -43'sd2147483648) begin
            sat[c] = 32'sh80000000;
         end else begin
            sat[c] = sub_ff[c][31:0];
         end
      end
      out_in.face_grad_x   = sat[0];
      out_in.face_grad_y   = sat[1];
      out_in.face_grad_z   = sat[2];
      out_in.zero_distance = sub_zero_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff       <= req_data;

         s1_pl_ff    <= s1_pl_in;
         s1_pr_ff    <= s1_pr_in;
         s1_sq_ff    <= s1_sq_in;
         s1_diff_ff  <= s1_diff_in;
         s1_d_ff     <= dd;

         s2_sum_ff   <= s2_sum_in;
         s2_m2a_ff   <= s2_m2a_in;
         s2_sq2_ff   <= s1_sq_ff[2];
         s2_diff_ff  <= s1_diff_ff;
         s2_d_ff     <= s1_d_ff;

         s3_rmag_ff  <= s3_rmag_in;
         s3_neg_ff   <= s3_neg_in;
         s3_m2_ff    <= s3_m2_in;
         s3_diff_ff  <= s2_diff_ff;
         s3_d_ff     <= s2_d_ff;

         s4_avg_ff   <= s4_avg_in;
         s4_m2_ff    <= s3_m2_ff;
         s4_zero_ff  <= s4_zero_in;
         s4_diff_ff  <= s3_diff_ff;
         s4_d_ff     <= s3_d_ff;

         s5_prod_ff  <= s5_prod_in;
         s5_dterm_ff <= s5_dterm_in;
         s5_avg_ff   <= s4_avg_ff;
         s5_d_ff     <= s4_d_ff;
         s5_m2_ff    <= s4_m2_ff;
         s5_zero_ff  <= s4_zero_ff;

         s6_s01_ff   <= s6_s01_in;
         s6_s2d_ff   <= s6_s2d_in;
         s6_avg_ff   <= s5_avg_ff;
         s6_d_ff     <= s5_d_ff;
         s6_m2_ff    <= s5_m2_ff;
         s6_zero_ff  <= s5_zero_ff;

         s7_n_ff     <= s7_n_in;
         s7_avg_ff   <= s6_avg_ff;
         s7_d_ff     <= s6_d_ff;
         s7_m2_ff    <= s6_m2_ff;
         s7_zero_ff  <= s6_zero_ff;

         s8_nm_ff    <= s8_nm_in;
         s8_neg_ff   <= s8_neg_in;
         s8_dm_ff    <= s8_dm_in;
         s8_avg_ff   <= s7_avg_ff;
         s8_m2_ff    <= s7_m2_ff;
         s8_zero_ff  <= s7_zero_ff;

         s9_plo_ff   <= s9_plo_in;
         s9_pmid_ff  <= s9_pmid_in;
         s9_phi_ff   <= s9_phi_in;
         s9_neg_ff   <= s8_neg_ff;
         s9_avg_ff   <= s8_avg_ff;
         s9_m2_ff    <= s8_m2_ff;
         s9_zero_ff  <= s8_zero_ff;

         s10_p_ff    <= s10_p_in;
         s10_neg_ff  <= s9_neg_ff;
         s10_avg_ff  <= s9_avg_ff;
         s10_m2_ff   <= s9_m2_ff;
         s10_zero_ff <= s9_zero_ff;

         div_ff      <= div_in;

         rnd_mq_ff   <= rnd_mq_in;
         rnd_neg_ff  <= div_ff[DivSteps].neg;
         for (int c = 0; c < 3; c++) begin
            rnd_avg_ff[c] <= $signed(div_ff[DivSteps].avg[c]);
         end
         rnd_zero_ff <= div_ff[DivSteps].zero;

         sub_ff      <= sub_in;
         sub_zero_ff <= rnd_zero_ff;

         out_ff      <= out_in;
      end
   end

   `FGC_ASSERT_NEXT(a_enter, req_valid && req_ready, valid_ff[0], "accepted face lost at entry")

   `FGC_ASSERT(a_avg_range, !valid_ff[4] || ((s4_avg_ff[0][32] == s4_avg_ff[0][31]) && (s4_avg_ff[1][32] == s4_avg_ff[1][31]) && (s4_avg_ff[2][32] == s4_avg_ff[2][31])), "average outside 32 bit range")

   `FGC_ASSERT(a_zero_flag, !valid_ff[RndStage-1] || (div_ff[DivSteps].zero == (div_ff[DivSteps].m2 == '0)), "zero distance flag out of step with squared length")

   `FGC_ASSERT(a_rem_bound, !valid_ff[RndStage-1] || div_ff[DivSteps].zero || ((div_ff[DivSteps].ovf[0] || (div_ff[DivSteps].rem[0] < {1'b0, div_ff[DivSteps].m2})) && (div_ff[DivSteps].ovf[1] || (div_ff[DivSteps].rem[1] < {1'b0, div_ff[DivSteps].m2})) && (div_ff[DivSteps].ovf[2] || (div_ff[DivSteps].rem[2] < {1'b0, div_ff[DivSteps].m2}))), "divider remainder not below divisor")

endmodule
